/* rtl/friction_cone_projection_macros.svh */
// Assertion macros for the friction cone projection block.
// Used by the top level; needs nothing else.
`ifndef FRICTION_CONE_PROJECTION_MACROS_SVH
`define FRICTION_CONE_PROJECTION_MACROS_SVH

// a implies b in the same cycle
`define FCP_ASSERT_NOW(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// a implies b in the next cycle
`define FCP_ASSERT_NEXT(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

/* rtl/fcp_pkg.sv */
// Shared constants, codes and the pipeline item type of the friction cone projection.
// No dependencies.
package fcp_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int REGION_W   = 3;
   localparam int MU_W       = 20;
   localparam int COH_W      = 31;
   localparam int SQ_W       = 64;
   localparam int SQRT_STEPS = 32;
   localparam int F_W        = 32;
   localparam int FSH_W      = F_W + FRAC_BITS;
   localparam int MUS_W      = MU_W + 33;
   localparam int CMP_W      = (FSH_W + 1 > MUS_W) ? FSH_W + 1 : MUS_W;
   localparam int FMU_W      = F_W + MU_W;
   localparam int SF_W       = 32 + FRAC_BITS;
   localparam int SUM_W      = ((FMU_W > SF_W) ? FMU_W : SF_W) + 2;
   localparam int NUM_W      = SUM_W - 1;
   localparam int DEN_W      = ((2 * MU_W > 2 * FRAC_BITS) ? 2 * MU_W : 2 * FRAC_BITS) + 1;
   localparam int NQ_W       = 31;
   localparam int SH1        = NQ_W - FRAC_BITS;
   localparam int DC1_W      = (NUM_W > DEN_W) ? NUM_W : DEN_W;
   localparam int T_W        = NQ_W + MU_W;
   localparam int TL_W       = 26;
   localparam int TH_W       = T_W - TL_W;
   localparam int PROD_W     = 32 + T_W;
   localparam int Q2_W       = 32;
   localparam int R2I_W      = PROD_W - Q2_W;
   localparam int DC2_W      = (R2I_W > FSH_W) ? R2I_W : FSH_W;

   localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] S32_MIN = 32'h8000_0000;

   localparam logic [MODE_W-1:0] MODE_NORMAL  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SLIDING = 2'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_MODE = 2'd1;

   localparam logic [REGION_W-1:0] REG_INSIDE       = 3'd0;
   localparam logic [REGION_W-1:0] REG_POLAR        = 3'd1;
   localparam logic [REGION_W-1:0] REG_PROJECTED    = 3'd2;
   localparam logic [REGION_W-1:0] REG_FRICTIONLESS = 3'd3;
   localparam logic [REGION_W-1:0] REG_NORMAL       = 3'd4;
   localparam logic [REGION_W-1:0] REG_PASS         = 3'd5;

   typedef struct packed {
      logic [MODE_W-1:0]        lmode;
      logic [MODE_W-1:0]        gmode;
      logic signed [31:0]       n;
      logic signed [31:0]       u;
      logic signed [31:0]       v;
      logic signed [31:0]       s;
      logic [MU_W-1:0]          mu;
      logic [COH_W-1:0]         c;
      logic [SQ_W-1:0]          uu;
      logic [SQ_W-1:0]          vv;
      logic [SQ_W-1:0]          sq_x;
      logic [SQ_W-1:0]          sq_r;
      logic signed [MUS_W-1:0]  mus;
      logic [DEN_W-1:0]         den;
      logic [F_W-1:0]           f;
      logic [FMU_W-1:0]         fmu;
      logic                     in_cone;
      logic                     polar;
      logic [NUM_W-1:0]         num;
      logic [DEN_W-1:0]         rem1;
      logic [NQ_W-1:0]          d1_bits;
      logic [NQ_W-1:0]          nq;
      logic                     ovf1;
      logic [NQ_W-1:0]          np;
      logic [T_W-1:0]           t;
      logic [31:0]              mag_u;
      logic [31:0]              mag_v;
      logic [FSH_W-1:0]         fd;
      logic [32+TL_W-1:0]       pul;
      logic [32+TL_W-1:0]       pvl;
      logic [32+TH_W-1:0]       puh;
      logic [32+TH_W-1:0]       pvh;
      logic [PROD_W-1:0]        prod_u;
      logic [PROD_W-1:0]        prod_v;
      logic [FSH_W-1:0]         rem_u;
      logic [FSH_W-1:0]         rem_v;
      logic [Q2_W-1:0]          bits_u;
      logic [Q2_W-1:0]          bits_v;
      logic [Q2_W-1:0]          q_u;
      logic [Q2_W-1:0]          q_v;
      logic                     ovf_u;
      logic                     ovf_v;
   } item_type;

endpackage

/* rtl/fcp_sqrt.sv */
// Pipelined integer square root of the tangent magnitude squared, one result bit per stage.
// Depends on fcp_pkg (item_type, SQ_W, SQRT_STEPS).
module fcp_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  fcp_pkg::item_type in_item,
   output logic              out_valid,
   output fcp_pkg::item_type out_item
);
   import fcp_pkg::*;

   logic [SQRT_STEPS-1:0] valid_ff;
   item_type              item_ff [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam int SHIFT = 2 * (SQRT_STEPS - 1 - k);
      item_type        src;
      logic            src_valid;
      item_type        item_in;
      logic [SQ_W-1:0] trial;

      if (k == 0) begin : g_first
         assign src       = in_item;
         assign src_valid = in_valid;
      end else begin : g_next
         assign src       = item_ff[k-1];
         assign src_valid = valid_ff[k-1];
      end

      always_comb begin
         item_in = src;
         trial   = src.sq_r + (SQ_W'(1) << SHIFT);
         if (src.sq_x >= trial) begin
            item_in.sq_x = src.sq_x - trial;
            item_in.sq_r = (src.sq_r >> 1) + (SQ_W'(1) << SHIFT);
         end else begin
            item_in.sq_r = src.sq_r >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= src_valid;
         end
         item_ff[k] <= item_in;
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS-1];
   assign out_item  = item_ff[SQRT_STEPS-1];

endmodule

/* rtl/friction_cone_projection.sv */
// Top level of the friction cone projection: config registers, pipeline stages, dividers.
// Depends on fcp_pkg, fcp_sqrt and friction_cone_projection_macros.svh.
//
//  channel | ports                        | transfer
//  --------+------------------------------+------------------------------------
//  request | start, busy, req_*           | start high and busy low at the edge
//  result  | rsp_valid, rsp_*             | rsp_valid high for one cycle
//  config  | csr_valid, csr_ready, csr_*  | csr_valid and csr_ready both high
//
// One item enters per cycle; its result passes through the capture register, 2 setup
// stages, 32 square root stages, 2 cone test stages, divider setup, 31 stages of the
// normal divider, 5 scaling stages, 32 stages of the tangent divider and the output
// register before it reaches the result ports.
// Synchronous reset clears the valid bits and sets both modes to sliding; busy is
// high only while reset is. The receiver cannot stall, so the pipeline never holds.
`include "friction_cone_projection_macros.svh"

module friction_cone_projection (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [31:0]               req_normal_in,
   input  logic signed [31:0]               req_tangent_u_in,
   input  logic signed [31:0]               req_tangent_v_in,
   input  logic [fcp_pkg::MU_W-1:0]         req_friction_coef,
   input  logic [fcp_pkg::COH_W-1:0]        req_cohesion_in,
   output logic                             rsp_valid,
   output logic signed [31:0]               rsp_normal_out,
   output logic signed [31:0]               rsp_tangent_u_out,
   output logic signed [31:0]               rsp_tangent_v_out,
   output logic [fcp_pkg::REGION_W-1:0]     rsp_region,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fcp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fcp_pkg::MODE_W-1:0]       csr_data
);
   import fcp_pkg::*;

   function automatic logic [31:0] sat_tangent(input logic neg, input logic ovf,
                                               input logic [31:0] q);
      logic big;
      big = ovf | q[31];
      if (neg) begin
         sat_tangent = big ? S32_MIN : (~q + 32'd1);
      end else begin
         sat_tangent = big ? S32_MAX : q;
      end
   endfunction

   logic [MODE_W-1:0] local_mode_ff;
   logic [MODE_W-1:0] global_mode_ff;

   item_type st0_in, st0_ff, sta_in, sta_ff, stb_in, stb_ff, sq_item;
   item_type stc_in, stc_ff, std_in, std_ff, ste_in, ste_ff;
   item_type stf_in, stf_ff, stg_in, stg_ff, sth_in, sth_ff, sti_in, sti_ff;
   item_type stj_in, stj_ff;
   item_type d1_ff [NQ_W];
   item_type d2_ff [Q2_W];
   logic     v0_ff, va_ff, vb_ff, sq_valid, vc_ff, vd_ff, ve_ff;
   logic     vf_ff, vg_ff, vh_ff, vi_ff, vj_ff;
   logic [NQ_W-1:0] d1_valid_ff;
   logic [Q2_W-1:0] d2_valid_ff;

   logic                rsp_valid_ff;
   logic signed [31:0]  rsp_normal_ff, rsp_normal_in;
   logic signed [31:0]  rsp_tu_ff, rsp_tu_in;
   logic signed [31:0]  rsp_tv_ff, rsp_tv_in;
   logic [REGION_W-1:0] rsp_region_ff, rsp_region_in;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         local_mode_ff  <= MODE_SLIDING;
         global_mode_ff <= MODE_SLIDING;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LOCAL_MODE:  local_mode_ff  <= csr_data;
            CSR_GLOBAL_MODE: global_mode_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // capture
   always_comb begin
      st0_in       = '0;
      st0_in.lmode = local_mode_ff;
      st0_in.gmode = global_mode_ff;
      st0_in.n     = req_normal_in;
      st0_in.u     = req_tangent_u_in;
      st0_in.v     = req_tangent_v_in;
      st0_in.mu    = req_friction_coef;
      st0_in.c     = req_cohesion_in;
   end

   // shifted normal and squares
   always_comb begin : p_stage_a
      logic signed [32:0] sum_a;
      logic signed [63:0] uu_a;
      logic signed [63:0] vv_a;
      sta_in = st0_ff;
      sum_a  = {st0_ff.n[31], st0_ff.n} + {2'b00, st0_ff.c};
      if (sum_a[32] != sum_a[31]) begin
         sta_in.s = sum_a[32] ? S32_MIN : S32_MAX;
      end else begin
         sta_in.s = sum_a[31:0];
      end
      uu_a      = 64'(st0_ff.u) * 64'(st0_ff.u);
      vv_a      = 64'(st0_ff.v) * 64'(st0_ff.v);
      sta_in.uu = uu_a;
      sta_in.vv = vv_a;
   end

   // magnitude squared, mu*s, denominator
   always_comb begin : p_stage_b
      logic signed [MU_W:0] mu_b;
      stb_in      = sta_ff;
      mu_b        = {1'b0, sta_ff.mu};
      stb_in.sq_x = sta_ff.uu + sta_ff.vv;
      stb_in.sq_r = '0;
      stb_in.mus  = MUS_W'(mu_b) * MUS_W'(sta_ff.s);
      stb_in.den  = DEN_W'(sta_ff.mu) * DEN_W'(sta_ff.mu) + (DEN_W'(1) << (2 * FRAC_BITS));
   end

   fcp_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vb_ff),
      .in_item   (stb_ff),
      .out_valid (sq_valid),
      .out_item  (sq_item)
   );

   // inside test and f*mu
   always_comb begin : p_stage_c
      logic signed [CMP_W-1:0] fsh_c;
      logic signed [CMP_W-1:0] mus_c;
      stc_in         = sq_item;
      stc_in.f       = sq_item.sq_r[F_W-1:0];
      stc_in.fmu     = FMU_W'(sq_item.sq_r[F_W-1:0]) * FMU_W'(sq_item.mu);
      fsh_c          = CMP_W'({1'b0, sq_item.sq_r[F_W-1:0], {FRAC_BITS{1'b0}}});
      mus_c          = CMP_W'(sq_item.mus);
      stc_in.in_cone = fsh_c < mus_c;
   end

   // polar test and projection numerator
   always_comb begin : p_stage_d
      logic signed [SUM_W-1:0] sf_d;
      logic signed [SUM_W-1:0] fmu_d;
      logic signed [SUM_W-1:0] sum_d;
      std_in       = stc_ff;
      sf_d         = SUM_W'(stc_ff.s) <<< FRAC_BITS;
      fmu_d        = SUM_W'(stc_ff.fmu);
      sum_d        = fmu_d + sf_d;
      std_in.polar = sum_d[SUM_W-1] || (stc_ff.s == 32'sd0) || (stc_ff.f == '0);
      std_in.num   = sum_d[NUM_W-1:0];
   end

   // normal divider setup: overflow check on the top part of num << FRAC_BITS
   always_comb begin
      ste_in         = std_ff;
      ste_in.ovf1    = DC1_W'(std_ff.num >> SH1) >= DC1_W'(std_ff.den);
      ste_in.rem1    = DEN_W'(std_ff.num >> SH1);
      ste_in.d1_bits = NQ_W'({std_ff.num, {FRAC_BITS{1'b0}}});
      ste_in.nq      = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
      end else begin
         v0_ff <= start && !busy;
         va_ff <= v0_ff;
         vb_ff <= va_ff;
         vc_ff <= sq_valid;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
      end
      st0_ff <= st0_in;
      sta_ff <= sta_in;
      stb_ff <= stb_in;
      stc_ff <= stc_in;
      std_ff <= std_in;
      ste_ff <= ste_in;
   end

   // normal divider, one quotient bit per stage
   for (genvar j = 0; j < NQ_W; j++) begin : g_div1
      item_type         src;
      logic             src_valid;
      item_type         item_in;
      logic [DEN_W:0]   tmp;

      if (j == 0) begin : g_first
         assign src       = ste_ff;
         assign src_valid = ve_ff;
      end else begin : g_next
         assign src       = d1_ff[j-1];
         assign src_valid = d1_valid_ff[j-1];
      end

      always_comb begin
         item_in         = src;
         tmp             = {src.rem1, src.d1_bits[NQ_W-1]};
         item_in.d1_bits = src.d1_bits << 1;
         if (tmp >= {1'b0, src.den}) begin
            item_in.rem1 = DEN_W'(tmp - {1'b0, src.den});
            item_in.nq   = {src.nq[NQ_W-2:0], 1'b1};
         end else begin
            item_in.rem1 = tmp[DEN_W-1:0];
            item_in.nq   = {src.nq[NQ_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d1_valid_ff[j] <= 1'b0;
         end else begin
            d1_valid_ff[j] <= src_valid;
         end
         d1_ff[j] <= item_in;
      end
   end

   // clamp n', tangent magnitudes, f << FRAC_BITS
   always_comb begin
      stf_in       = d1_ff[NQ_W-1];
      stf_in.np    = d1_ff[NQ_W-1].ovf1 ? {NQ_W{1'b1}} : d1_ff[NQ_W-1].nq;
      stf_in.mag_u = d1_ff[NQ_W-1].u[31] ? (~d1_ff[NQ_W-1].u + 32'd1) : d1_ff[NQ_W-1].u;
      stf_in.mag_v = d1_ff[NQ_W-1].v[31] ? (~d1_ff[NQ_W-1].v + 32'd1) : d1_ff[NQ_W-1].v;
      stf_in.fd    = {d1_ff[NQ_W-1].f, {FRAC_BITS{1'b0}}};
   end

   // t = n' * mu
   always_comb begin
      stg_in   = stf_ff;
      stg_in.t = T_W'(stf_ff.np) * T_W'(stf_ff.mu);
   end

   // partial products of |u| * t and |v| * t
   always_comb begin
      sth_in     = stg_ff;
      sth_in.pul = (32 + TL_W)'(stg_ff.mag_u) * (32 + TL_W)'(stg_ff.t[TL_W-1:0]);
      sth_in.puh = (32 + TH_W)'(stg_ff.mag_u) * (32 + TH_W)'(stg_ff.t[T_W-1:TL_W]);
      sth_in.pvl = (32 + TL_W)'(stg_ff.mag_v) * (32 + TL_W)'(stg_ff.t[TL_W-1:0]);
      sth_in.pvh = (32 + TH_W)'(stg_ff.mag_v) * (32 + TH_W)'(stg_ff.t[T_W-1:TL_W]);
   end

   always_comb begin
      sti_in        = sth_ff;
      sti_in.prod_u = PROD_W'(sth_ff.pul) + (PROD_W'(sth_ff.puh) << TL_W);
      sti_in.prod_v = PROD_W'(sth_ff.pvl) + (PROD_W'(sth_ff.pvh) << TL_W);
   end

   // tangent divider setup: quotient at or above 2^32 saturates anyway
   always_comb begin
      stj_in        = sti_ff;
      stj_in.ovf_u  = DC2_W'(sti_ff.prod_u >> Q2_W) >= DC2_W'(sti_ff.fd);
      stj_in.ovf_v  = DC2_W'(sti_ff.prod_v >> Q2_W) >= DC2_W'(sti_ff.fd);
      stj_in.rem_u  = FSH_W'(sti_ff.prod_u >> Q2_W);
      stj_in.rem_v  = FSH_W'(sti_ff.prod_v >> Q2_W);
      stj_in.bits_u = sti_ff.prod_u[Q2_W-1:0];
      stj_in.bits_v = sti_ff.prod_v[Q2_W-1:0];
      stj_in.q_u    = '0;
      stj_in.q_v    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
         vg_ff <= 1'b0;
         vh_ff <= 1'b0;
         vi_ff <= 1'b0;
         vj_ff <= 1'b0;
      end else begin
         vf_ff <= d1_valid_ff[NQ_W-1];
         vg_ff <= vf_ff;
         vh_ff <= vg_ff;
         vi_ff <= vh_ff;
         vj_ff <= vi_ff;
      end
      stf_ff <= stf_in;
      stg_ff <= stg_in;
      sth_ff <= sth_in;
      sti_ff <= sti_in;
      stj_ff <= stj_in;
   end

   // tangent dividers, both lanes, one quotient bit per stage
   for (genvar j = 0; j < Q2_W; j++) begin : g_div2
      item_type       src;
      logic           src_valid;
      item_type       item_in;
      logic [FSH_W:0] tmp_u;
      logic [FSH_W:0] tmp_v;

      if (j == 0) begin : g_first
         assign src       = stj_ff;
         assign src_valid = vj_ff;
      end else begin : g_next
         assign src       = d2_ff[j-1];
         assign src_valid = d2_valid_ff[j-1];
      end

      always_comb begin
         item_in        = src;
         tmp_u          = {src.rem_u, src.bits_u[Q2_W-1]};
         tmp_v          = {src.rem_v, src.bits_v[Q2_W-1]};
         item_in.bits_u = src.bits_u << 1;
         item_in.bits_v = src.bits_v << 1;
         if (tmp_u >= {1'b0, src.fd}) begin
            item_in.rem_u = FSH_W'(tmp_u - {1'b0, src.fd});
            item_in.q_u   = {src.q_u[Q2_W-2:0], 1'b1};
         end else begin
            item_in.rem_u = tmp_u[FSH_W-1:0];
            item_in.q_u   = {src.q_u[Q2_W-2:0], 1'b0};
         end
         if (tmp_v >= {1'b0, src.fd}) begin
            item_in.rem_v = FSH_W'(tmp_v - {1'b0, src.fd});
            item_in.q_v   = {src.q_v[Q2_W-2:0], 1'b1};
         end else begin
            item_in.rem_v = tmp_v[FSH_W-1:0];
            item_in.q_v   = {src.q_v[Q2_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d2_valid_ff[j] <= 1'b0;
         end else begin
            d2_valid_ff[j] <= src_valid;
         end
         d2_ff[j] <= item_in;
      end
   end

   // select the result by mode and region
   always_comb begin : p_result
      item_type fin;
      logic     clamp;
      logic     clear_t;
      fin     = d2_ff[Q2_W-1];
      clamp   = (fin.lmode == MODE_NORMAL) || ((fin.lmode == MODE_SLIDING) && (fin.mu == '0));
      clear_t = (fin.lmode == MODE_SLIDING) || (fin.gmode == MODE_SLIDING);
      rsp_normal_in = fin.n;
      rsp_tu_in     = fin.u;
      rsp_tv_in     = fin.v;
      rsp_region_in = REG_PASS;
      priority if (clamp) begin
         rsp_normal_in = fin.s[31] ? 32'sd0 : (fin.s - {1'b0, fin.c});
         rsp_tu_in     = clear_t ? 32'sd0 : fin.u;
         rsp_tv_in     = clear_t ? 32'sd0 : fin.v;
         rsp_region_in = (fin.lmode == MODE_NORMAL) ? REG_NORMAL : REG_FRICTIONLESS;
      end else if (fin.lmode == MODE_SLIDING) begin
         priority if (fin.in_cone) begin
            rsp_normal_in = fin.s - {1'b0, fin.c};
            rsp_region_in = REG_INSIDE;
         end else if (fin.polar) begin
            rsp_normal_in = 32'd0 - {1'b0, fin.c};
            rsp_tu_in     = 32'sd0;
            rsp_tv_in     = 32'sd0;
            rsp_region_in = REG_POLAR;
         end else begin
            rsp_normal_in = {1'b0, fin.np} - {1'b0, fin.c};
            rsp_tu_in     = sat_tangent(fin.u[31], fin.ovf_u, fin.q_u);
            rsp_tv_in     = sat_tangent(fin.v[31], fin.ovf_v, fin.q_v);
            rsp_region_in = REG_PROJECTED;
         end
      end else begin
         rsp_region_in = REG_PASS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= d2_valid_ff[Q2_W-1];
      end
      rsp_normal_ff <= rsp_normal_in;
      rsp_tu_ff     <= rsp_tu_in;
      rsp_tv_ff     <= rsp_tv_in;
      rsp_region_ff <= rsp_region_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_normal_out    = rsp_normal_ff;
   assign rsp_tangent_u_out = rsp_tu_ff;
   assign rsp_tangent_v_out = rsp_tv_ff;
   assign rsp_region        = rsp_region_ff;

   `FCP_ASSERT_NOW(a_region_code, clock, reset, rsp_valid, rsp_region <= REG_PASS, "bad region code")
   `FCP_ASSERT_NOW(a_zero_tangents, clock, reset, rsp_valid && (rsp_region == REG_POLAR || rsp_region == REG_FRICTIONLESS), rsp_tangent_u_out == 32'sd0 && rsp_tangent_v_out == 32'sd0, "tangents not cleared")
   `FCP_ASSERT_NOW(a_div1_rem, clock, reset, d1_valid_ff[NQ_W-1] && !d1_ff[NQ_W-1].ovf1, d1_ff[NQ_W-1].rem1 < d1_ff[NQ_W-1].den, "normal divider remainder out of range")
   `FCP_ASSERT_NEXT(a_tail_valid, clock, reset, d2_valid_ff[Q2_W-1], rsp_valid, "result strobe lost")

endmodule

/* test/friction_cone_projection_tb.sv */
// Self-checking bench for friction_cone_projection: directed rows, then random contacts
// under several mode settings, each result compared with a typed expectation or an in-bench cone projection.
// Depends on fcp_pkg and the friction_cone_projection RTL.
module friction_cone_projection_tb;
   import fcp_pkg::*;

   localparam logic [MODE_W-1:0] MODE_PASS     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_PASS_ALT = 2'd3;
   localparam int LATENCY     = 107;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 500;
   localparam int NUM_PHASES  = 8;

   typedef struct {
      logic signed [31:0] normal;
      logic signed [31:0] tan_u;
      logic signed [31:0] tan_v;
      logic [REGION_W-1:0] region;
   } impulse_t;

   typedef struct {
      logic signed [31:0] normal;
      logic signed [31:0] tan_u;
      logic signed [31:0] tan_v;
      logic [MU_W-1:0]    mu;
      logic [COH_W-1:0]   coh;
      bit                 typed;
      impulse_t           want;
   } contact_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_normal_in = '0;
   logic signed [31:0] req_tangent_u_in = '0;
   logic signed [31:0] req_tangent_v_in = '0;
   logic [MU_W-1:0]    req_friction_coef = '0;
   logic [COH_W-1:0]   req_cohesion_in = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_normal_out, rsp_tangent_u_out, rsp_tangent_v_out;
   logic [REGION_W-1:0] rsp_region;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [MODE_W-1:0]    csr_data = '0;

   friction_cone_projection dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_normal_in(req_normal_in), .req_tangent_u_in(req_tangent_u_in),
      .req_tangent_v_in(req_tangent_v_in), .req_friction_coef(req_friction_coef),
      .req_cohesion_in(req_cohesion_in), .rsp_valid(rsp_valid),
      .rsp_normal_out(rsp_normal_out), .rsp_tangent_u_out(rsp_tangent_u_out),
      .rsp_tangent_v_out(rsp_tangent_v_out), .rsp_region(rsp_region),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [MODE_W-1:0] local_mode_q  = MODE_SLIDING;
   logic [MODE_W-1:0] global_mode_q = MODE_SLIDING;
   impulse_t pending_projections[$];
   contact_t cur_contact;
   int accepted_contacts = 0;
   int csr_transfers = 0;
   int mismatches = 0;
   int cycles = 0;

   function automatic logic signed [63:0] clamp32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // floor(a*b/d), saturating at all ones
   function automatic logic [63:0] scaled_quot(input logic [63:0] a, b, d);
      logic [127:0] q;
      q = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
      if (q[127:64] != 0) return '1;
      return q[63:0];
   endfunction

   function automatic logic signed [63:0] scale_tan(input logic signed [63:0] comp,
                                                    input logic [63:0] t, fd);
      logic [63:0] mag, q;
      logic signed [63:0] m;
      mag = (comp < 0) ? -comp : comp;
      q = scaled_quot(mag, t, fd);
      m = (q > 64'd2147483648) ? 64'sd2147483648 : $signed(q);
      return clamp32(comp < 0 ? -m : m);
   endfunction

   function automatic impulse_t project_contact(input contact_t x,
                                                input logic [MODE_W-1:0] lm, gm);
      impulse_t r;
      logic signed [63:0] n, u, v, c, s, no, uo, vo, fmu, sf, mu_s;
      logic [63:0] mu, f, den, np, t;
      n = 64'(x.normal);
      u = 64'(x.tan_u);
      v = 64'(x.tan_v);
      c = {33'd0, x.coh};
      mu = {44'd0, x.mu};
      mu_s = $signed(mu);
      s = clamp32(n + c);
      no = n;
      uo = u;
      vo = v;
      r.region = REG_PASS;
      if (lm == MODE_NORMAL || (lm == MODE_SLIDING && mu == 0)) begin
         no = (s < 0) ? 64'sd0 : s - c;
         if (lm == MODE_SLIDING || gm == MODE_SLIDING) begin
            uo = 0;
            vo = 0;
         end
         r.region = (lm == MODE_NORMAL) ? REG_NORMAL : REG_FRICTIONLESS;
      end else if (lm == MODE_SLIDING) begin
         f = int_sqrt(u * u + v * v);
         fmu = $signed(f * mu);
         sf = s * 64'sd65536;
         if ($signed(f << FRAC_BITS) < mu_s * s) begin
            no = s - c;
            r.region = REG_INSIDE;
         end else if (fmu < -sf || s == 0 || f == 0) begin
            no = -c;
            uo = 0;
            vo = 0;
            r.region = REG_POLAR;
         end else begin
            den = mu * mu + (64'd1 << (2 * FRAC_BITS));
            np = scaled_quot(fmu + sf, 64'd1 << FRAC_BITS, den);
            if (np > 64'd2147483647) np = 64'd2147483647;
            t = np * mu;
            uo = scale_tan(u, t, f << FRAC_BITS);
            vo = scale_tan(v, t, f << FRAC_BITS);
            no = $signed(np) - c;
            r.region = REG_PROJECTED;
         end
      end
      r.normal = no[31:0];
      r.tan_u = uo[31:0];
      r.tan_v = vo[31:0];
      return r;
   endfunction

   // record transfers, apply register writes, check results
   always @(posedge clock) begin
      impulse_t want;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("friction_cone_projection_tb: errors");
         $finish;
      end
      if (!reset && csr_valid && csr_ready) begin
         if (csr_index == CSR_LOCAL_MODE) local_mode_q = csr_data;
         else if (csr_index == CSR_GLOBAL_MODE) global_mode_q = csr_data;
         csr_transfers = csr_transfers + 1;
      end
      if (!reset && start && !busy) begin
         if (cur_contact.typed) pending_projections.push_back(cur_contact.want);
         else pending_projections.push_back(
            project_contact(cur_contact, local_mode_q, global_mode_q));
         accepted_contacts = accepted_contacts + 1;
      end
      if (!reset && rsp_valid) begin
         if (pending_projections.size() == 0) begin
            $display("%0t: result with nothing expected", $time);
            mismatches = mismatches + 1;
         end else begin
            want = pending_projections.pop_front();
            if (rsp_normal_out !== want.normal) begin
               $display("%0t: normal exp %0d got %0d", $time, want.normal, rsp_normal_out);
               mismatches = mismatches + 1;
            end
            if (rsp_tangent_u_out !== want.tan_u) begin
               $display("%0t: tan_u exp %0d got %0d", $time, want.tan_u, rsp_tangent_u_out);
               mismatches = mismatches + 1;
            end
            if (rsp_tangent_v_out !== want.tan_v) begin
               $display("%0t: tan_v exp %0d got %0d", $time, want.tan_v, rsp_tangent_v_out);
               mismatches = mismatches + 1;
            end
            if (rsp_region !== want.region) begin
               $display("%0t: region exp %0d got %0d", $time, want.region, rsp_region);
               mismatches = mismatches + 1;
            end
         end
      end
   end

   task automatic write_mode(input logic [CSR_IDX_W-1:0] idx, input logic [MODE_W-1:0] val);
      int seen;
      seen = csr_transfers;
      csr_index = idx;
      csr_data = val;
      csr_valid = 1'b1;
      while (csr_transfers == seen) @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // hold the item until it transfers, then idle each cycle at the given rate
   task automatic send_contact(input contact_t x, input int idle_pct);
      int seen;
      seen = accepted_contacts;
      cur_contact = x;
      req_normal_in = x.normal;
      req_tangent_u_in = x.tan_u;
      req_tangent_v_in = x.tan_v;
      req_friction_coef = x.mu;
      req_cohesion_in = x.coh;
      start = 1'b1;
      while (accepted_contacts == seen) @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic drain();
      while (pending_projections.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   function automatic contact_t row(input logic signed [31:0] n, u, v,
                                    input logic [MU_W-1:0] mu, input logic [COH_W-1:0] c);
      contact_t x;
      x.normal = n;
      x.tan_u = u;
      x.tan_v = v;
      x.mu = mu;
      x.coh = c;
      x.typed = 1'b0;
      x.want = '{0, 0, 0, REG_PASS};
      return x;
   endfunction

   function automatic contact_t typed_row(input logic signed [31:0] n, u, v,
                                          input logic [MU_W-1:0] mu,
                                          input logic [COH_W-1:0] c,
                                          input logic signed [31:0] wn, wu, wv,
                                          input logic [REGION_W-1:0] wr);
      contact_t x;
      x = row(n, u, v, mu, c);
      x.typed = 1'b1;
      x.want = '{wn, wu, wv, wr};
      return x;
   endfunction

   function automatic logic signed [31:0] rand_comp();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(2 * 65536 * 64)) - 65536 * 64;
         2: return $signed($urandom_range(4000)) - 2000;
         default: return $signed($urandom_range(65536 * 8));
      endcase
   endfunction

   function automatic contact_t rand_contact();
      logic [MU_W-1:0] mu;
      logic [COH_W-1:0] c;
      case ($urandom_range(5))
         0: mu = '0;
         1: mu = '1;
         2: mu = MU_W'($urandom);
         default: mu = MU_W'($urandom_range(2 * 65536));
      endcase
      case ($urandom_range(4))
         0: c = '0;
         1: c = '1;
         2: c = COH_W'($urandom);
         default: c = COH_W'($urandom_range(65536 * 4));
      endcase
      return row(rand_comp(), rand_comp(), rand_comp(), mu, c);
   endfunction

   contact_t directed[$];
   logic [MODE_W-1:0] lm_set[NUM_PHASES] = '{MODE_NORMAL, MODE_NORMAL, MODE_SLIDING,
      MODE_PASS, MODE_SLIDING, MODE_NORMAL, MODE_PASS_ALT, MODE_SLIDING};
   logic [MODE_W-1:0] gm_set[NUM_PHASES] = '{MODE_SLIDING, MODE_NORMAL, MODE_PASS,
      MODE_SLIDING, MODE_NORMAL, MODE_PASS, MODE_NORMAL, MODE_SLIDING};
   int idle_set[4] = '{0, 58, 29, 0};

   initial begin
      directed = '{
         typed_row(32'sd5, 32'sd3, 32'sd4, 0, 0, 32'sd5, 0, 0, REG_FRICTIONLESS),
         typed_row(-32'sd100, 32'sd7, -32'sd9, 0, 0, 0, 0, 0, REG_FRICTIONLESS),
         typed_row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 31'h7FFF_FFFF,
                   0, 0, 0, REG_FRICTIONLESS),
         typed_row(0, 0, 0, 65536, 0, 0, 0, 0, REG_POLAR),
         typed_row(32'sd655360, 0, 0, 65536, 0, 32'sd655360, 0, 0, REG_INSIDE),
         typed_row(-32'sd65536, 32'sd65536, 0, 65536, 0, 0, 0, 0, REG_PROJECTED),
         row(32'sd65536, 32'sd262144, 32'sd131072, 65536, 0),
         row(32'sd65536, -32'sd262144, -32'sd131072, 32768, 1000),
         row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 20'hFFFFF, 31'h7FFF_FFFF),
         row(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 20'hFFFFF, 0),
         row(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 1, 0),
         row(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 20'hFFFFF, 0),
         row(32'sd1, 32'sh7FFF_FFFF, 0, 20'hFFFFF, 0),
         row(-32'sd1000, 32'sd500, 32'sd500, 65536, 31'd2000),
         row(32'sh8000_0000, 32'sd10, 32'sd10, 65536, 31'h7FFF_FFFF),
         row(32'sd1, 32'sd1, 32'sd1, 1, 0),
         row(-32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA, 20'h55555, 31'h2AAA_AAAA),
         row(32'sh7FFF_0000, 32'sd65536, -32'sd65536, 20'hAAAAA, 31'h5555_5555)
      };
      repeat (10) @(negedge clock);
      reset = 1'b0;
      foreach (directed[i]) send_contact(directed[i], 0);
      start = 1'b0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         drain();
         write_mode(CSR_LOCAL_MODE, lm_set[p]);
         write_mode(CSR_GLOBAL_MODE, gm_set[p]);
         for (int k = 0; k < RANDOM_ITEMS / NUM_PHASES; k++)
            send_contact(rand_contact(), idle_set[p % 4]);
         start = 1'b0;
      end
      drain();
      if (mismatches == 0) $display("friction_cone_projection_tb: clean");
      else $display("friction_cone_projection_tb: errors");
      $finish;
   end

endmodule
